// ===== src/ata_pio_transfer_sequencer_core_macros.svh =====
// ----------------------------------------------------------------------------
// ATA PIO transfer sequencer assertion macros
// Immediate-implication and next-cycle-implication checks on aclk/aresetn.
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_TRANSFER_SEQUENCER_CORE_MACROS_SVH
`define ATA_PIO_TRANSFER_SEQUENCER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define APIO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define APIO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define APIO_ASSERT_NOW(label, ante, cons, msg)
`define APIO_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== src/atapio_seq_pkg.sv =====
// ----------------------------------------------------------------------------
// ATA PIO transfer sequencer package
// Transfer types, phase encoding, op/kind/result codes and task-file constants.
// ----------------------------------------------------------------------------
package atapio_seq_pkg;

    typedef struct packed {
        logic [1:0]  op;
        logic        secondary_bus;
        logic        slave_drive;
        logic [27:0] lba;
        logic [15:0] sector_count;
        logic        write_dir;
        logic [7:0]  status_byte;
        logic [15:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        channel;
        logic [2:0]  reg_index;
        logic [15:0] value;
        logic [2:0]  result_code;
        logic        needs_reset;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_BUSY  = 3'd1,
        PH_DRQ   = 3'd2,
        PH_DATA  = 3'd3,
        PH_FLUSH = 3'd4
    } phase_t;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_STATUS = 2'd1;
    localparam logic [1:0] OP_DATA   = 2'd2;

    localparam logic [2:0] KIND_REG_WR     = 3'd0;
    localparam logic [2:0] KIND_STATUS_REQ = 3'd1;
    localparam logic [2:0] KIND_DATA       = 3'd2;
    localparam logic [2:0] KIND_DONE       = 3'd3;
    localparam logic [2:0] KIND_SECTOR_RDY = 3'd4;

    localparam logic [2:0] RC_OK         = 3'd0;
    localparam logic [2:0] RC_OUTSIDE    = 3'd1;
    localparam logic [2:0] RC_BAD_COUNT  = 3'd2;
    localparam logic [2:0] RC_STUCK_BUSY = 3'd3;
    localparam logic [2:0] RC_DRIVE_ERR  = 3'd4;
    localparam logic [2:0] RC_NO_DATA    = 3'd5;
    localparam logic [2:0] RC_FLUSH_FAIL = 3'd6;

    localparam logic [2:0] TF_DATA     = 3'd0;
    localparam logic [2:0] TF_FEATURES = 3'd1;
    localparam logic [2:0] TF_COUNT    = 3'd2;
    localparam logic [2:0] TF_LBA_LO   = 3'd3;
    localparam logic [2:0] TF_LBA_MID  = 3'd4;
    localparam logic [2:0] TF_LBA_HI   = 3'd5;
    localparam logic [2:0] TF_DRIVE    = 3'd6;
    localparam logic [2:0] TF_COMMAND  = 3'd7;

    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam logic [7:0] CMD_FLUSH = 8'hE7;

    localparam logic [3:0] DRV_MASTER = 4'hE;
    localparam logic [3:0] DRV_SLAVE  = 4'hF;

    localparam int ST_BSY = 7;
    localparam int ST_DF  = 5;
    localparam int ST_DRQ = 3;
    localparam int ST_ERR = 0;

    localparam logic [1:0] CFG_BASE_LBA   = 2'd0;
    localparam logic [1:0] CFG_PART_SECT  = 2'd1;
    localparam logic [1:0] CFG_POLL_LIMIT = 2'd2;

    localparam logic [23:0] POLL_LIMIT_RESET = 24'd1000000;

    localparam int WORDS_PER_SECTOR = 256;
    localparam int WORD_IDX_W       = $clog2(WORDS_PER_SECTOR);
    localparam int QUEUE_DEPTH      = 8;
    localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== src/ata_pio_transfer_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// ATA PIO LBA28 transfer sequencer
// Host-side command, status-poll and data-word sequencing for PIO transfers.
// ----------------------------------------------------------------------------
// Each input transfer is decoded combinationally and its results (up to
// eight) are loaded into an eight-entry output queue that drains one result
// per cycle while m_ready is high. A new input is taken whenever the queue is
// empty or its final entry is leaving, so status samples and data words that
// yield a single result sustain one transfer per clock while m_ready is high;
// an accepted start request that passes its range and count checks fills the
// queue with eight results, and the next input is taken together with the
// eighth result. Configuration writes are always accepted (cfg_ready is high).
`include "ata_pio_transfer_sequencer_core_macros.svh"

module ata_pio_transfer_sequencer_core
    import atapio_seq_pkg::*;
#(
    parameter int MAX_SECTORS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [28:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    localparam int SECT_W = $clog2(MAX_SECTORS + 1);
    localparam logic [16:0] MaxCount = 17'(MAX_SECTORS);
    localparam logic [WORD_IDX_W-1:0] LastWord = WORD_IDX_W'(WORDS_PER_SECTOR - 1);

    logic [27:0] base_lba_reg;
    logic [28:0] part_sect_reg;
    logic [23:0] poll_limit_reg;

    phase_t                phase_reg, phase_next;
    logic                  write_mode_reg, write_mode_next;
    logic                  bus_sel_reg, bus_sel_next;
    logic [SECT_W-1:0]     sectors_left_reg, sectors_left_next;
    logic [WORD_IDX_W-1:0] word_index_reg, word_index_next;
    logic [23:0]           spin_count_reg, spin_count_next;

    out_item_t             queue_reg  [QUEUE_DEPTH];
    out_item_t             queue_next [QUEUE_DEPTH];
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    out_item_t             load_items [QUEUE_DEPTH];
    logic [QUEUE_CNT_W-1:0] load_cnt;

    logic        s_fire;
    logic        m_fire;
    logic [28:0] range_end;
    logic [27:0] abs_lba;
    logic [7:0]  drive_sel;
    logic        spin_ok;
    logic [SECT_W-1:0] sect_dec;

    function automatic out_item_t mk_item(input logic [2:0] kind, input logic chan,
                                          input logic [2:0] ridx, input logic [15:0] val,
                                          input logic [2:0] code);
        out_item_t r;
        r.kind        = kind;
        r.channel     = chan;
        r.reg_index   = ridx;
        r.value       = val;
        r.result_code = code;
        r.needs_reset = (kind == KIND_DONE) && (code >= RC_STUCK_BUSY);
        r.last        = 1'b0;
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign m_fire    = m_valid && m_ready;
    assign m_valid   = (cnt_reg != '0);
    assign s_ready   = (cnt_reg == '0) || ((cnt_reg == QUEUE_CNT_W'(1)) && m_ready);
    assign m_data    = queue_reg[0];

    assign range_end = 29'(s_data.lba) + 29'(s_data.sector_count);
    assign abs_lba   = s_data.lba + base_lba_reg;
    assign drive_sel = {(s_data.slave_drive ? DRV_SLAVE : DRV_MASTER), abs_lba[27:24]};
    assign spin_ok   = (spin_count_reg < poll_limit_reg);
    assign sect_dec  = (sectors_left_reg != '0) ? sectors_left_reg - SECT_W'(1)
                                                 : sectors_left_reg;

    always_comb begin
        phase_next        = phase_reg;
        write_mode_next   = write_mode_reg;
        bus_sel_next      = bus_sel_reg;
        sectors_left_next = sectors_left_reg;
        word_index_next   = word_index_reg;
        spin_count_next   = spin_count_reg;
        load_cnt          = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            load_items[i] = '0;
        end

        if (s_fire) begin
            case (s_data.op)
                OP_START: begin
                    if (phase_reg == PH_IDLE) begin
                        bus_sel_next = s_data.secondary_bus;
                        if ((part_sect_reg != '0) && (range_end > part_sect_reg)) begin
                            load_items[0] = mk_item(KIND_DONE, bus_sel_next, TF_DATA, '0,
                                                    RC_OUTSIDE);
                            load_cnt = QUEUE_CNT_W'(1);
                        end else if ((s_data.sector_count == '0) ||
                                     ({1'b0, s_data.sector_count} > MaxCount)) begin
                            load_items[0] = mk_item(KIND_DONE, bus_sel_next, TF_DATA, '0,
                                                    RC_BAD_COUNT);
                            load_cnt = QUEUE_CNT_W'(1);
                        end else begin
                            load_items[0] = mk_item(KIND_REG_WR, bus_sel_next, TF_DRIVE,
                                                    {8'h00, drive_sel}, RC_OK);
                            load_items[1] = mk_item(KIND_REG_WR, bus_sel_next, TF_FEATURES,
                                                    '0, RC_OK);
                            load_items[2] = mk_item(KIND_REG_WR, bus_sel_next, TF_COUNT,
                                                    {8'h00, s_data.sector_count[7:0]}, RC_OK);
                            load_items[3] = mk_item(KIND_REG_WR, bus_sel_next, TF_LBA_LO,
                                                    {8'h00, abs_lba[7:0]}, RC_OK);
                            load_items[4] = mk_item(KIND_REG_WR, bus_sel_next, TF_LBA_MID,
                                                    {8'h00, abs_lba[15:8]}, RC_OK);
                            load_items[5] = mk_item(KIND_REG_WR, bus_sel_next, TF_LBA_HI,
                                                    {8'h00, abs_lba[23:16]}, RC_OK);
                            load_items[6] = mk_item(KIND_REG_WR, bus_sel_next, TF_COMMAND,
                                                    {8'h00, (s_data.write_dir ? CMD_WRITE
                                                                              : CMD_READ)},
                                                    RC_OK);
                            load_items[7] = mk_item(KIND_STATUS_REQ, bus_sel_next, TF_COMMAND,
                                                    '0, RC_OK);
                            load_cnt          = QUEUE_CNT_W'(8);
                            write_mode_next   = s_data.write_dir;
                            sectors_left_next = s_data.sector_count[SECT_W-1:0];
                            word_index_next   = '0;
                            spin_count_next   = '0;
                            phase_next        = PH_BUSY;
                        end
                    end
                end
                OP_STATUS: begin
                    case (phase_reg)
                        PH_BUSY: begin
                            load_cnt = QUEUE_CNT_W'(1);
                            if (s_data.status_byte[ST_BSY]) begin
                                if (spin_ok) begin
                                    spin_count_next = spin_count_reg + 24'd1;
                                    load_items[0] = mk_item(KIND_STATUS_REQ, bus_sel_reg,
                                                            TF_COMMAND, '0, RC_OK);
                                end else begin
                                    phase_next    = PH_IDLE;
                                    load_items[0] = mk_item(KIND_DONE, bus_sel_reg, TF_DATA,
                                                            '0, RC_STUCK_BUSY);
                                end
                            end else begin
                                spin_count_next = '0;
                                phase_next      = PH_DRQ;
                                load_items[0]   = mk_item(KIND_STATUS_REQ, bus_sel_reg,
                                                          TF_COMMAND, '0, RC_OK);
                            end
                        end
                        PH_DRQ: begin
                            load_cnt = QUEUE_CNT_W'(1);
                            if (!s_data.status_byte[ST_DRQ] && !s_data.status_byte[ST_ERR]
                                && spin_ok) begin
                                spin_count_next = spin_count_reg + 24'd1;
                                load_items[0] = mk_item(KIND_STATUS_REQ, bus_sel_reg,
                                                        TF_COMMAND, '0, RC_OK);
                            end else if (s_data.status_byte[ST_ERR] ||
                                         s_data.status_byte[ST_DF]) begin
                                phase_next    = PH_IDLE;
                                load_items[0] = mk_item(KIND_DONE, bus_sel_reg, TF_DATA,
                                                        '0, RC_DRIVE_ERR);
                            end else if (!s_data.status_byte[ST_DRQ]) begin
                                phase_next    = PH_IDLE;
                                load_items[0] = mk_item(KIND_DONE, bus_sel_reg, TF_DATA,
                                                        '0, RC_NO_DATA);
                            end else begin
                                word_index_next = '0;
                                phase_next      = PH_DATA;
                                load_items[0]   = mk_item(KIND_SECTOR_RDY, bus_sel_reg,
                                                          TF_DATA, '0, RC_OK);
                            end
                        end
                        PH_FLUSH: begin
                            load_cnt = QUEUE_CNT_W'(1);
                            if (s_data.status_byte[ST_BSY] && spin_ok) begin
                                spin_count_next = spin_count_reg + 24'd1;
                                load_items[0] = mk_item(KIND_STATUS_REQ, bus_sel_reg,
                                                        TF_COMMAND, '0, RC_OK);
                            end else if (s_data.status_byte[ST_BSY] ||
                                         s_data.status_byte[ST_ERR] ||
                                         s_data.status_byte[ST_DF]) begin
                                phase_next    = PH_IDLE;
                                load_items[0] = mk_item(KIND_DONE, bus_sel_reg, TF_DATA,
                                                        '0, RC_FLUSH_FAIL);
                            end else begin
                                phase_next    = PH_IDLE;
                                load_items[0] = mk_item(KIND_DONE, bus_sel_reg, TF_DATA,
                                                        '0, RC_OK);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                OP_DATA: begin
                    if (phase_reg == PH_DATA) begin
                        load_items[0] = mk_item(KIND_DATA, bus_sel_reg, TF_DATA,
                                                s_data.data_word, RC_OK);
                        load_cnt = QUEUE_CNT_W'(1);
                        if (word_index_reg == LastWord) begin
                            word_index_next   = '0;
                            spin_count_next   = '0;
                            sectors_left_next = sect_dec;
                            load_cnt          = QUEUE_CNT_W'(2);
                            if (sect_dec != '0) begin
                                phase_next    = PH_BUSY;
                                load_items[1] = mk_item(KIND_STATUS_REQ, bus_sel_reg,
                                                        TF_COMMAND, '0, RC_OK);
                            end else if (write_mode_reg) begin
                                phase_next    = PH_FLUSH;
                                load_items[1] = mk_item(KIND_REG_WR, bus_sel_reg, TF_COMMAND,
                                                        {8'h00, CMD_FLUSH}, RC_OK);
                                load_items[2] = mk_item(KIND_STATUS_REQ, bus_sel_reg,
                                                        TF_COMMAND, '0, RC_OK);
                                load_cnt      = QUEUE_CNT_W'(3);
                            end else begin
                                phase_next    = PH_IDLE;
                                load_items[1] = mk_item(KIND_DONE, bus_sel_reg, TF_DATA,
                                                        '0, RC_OK);
                            end
                        end else begin
                            word_index_next = word_index_reg + WORD_IDX_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            load_items[i].last = (load_cnt != '0) &&
                                 (QUEUE_CNT_W'(i) == load_cnt - QUEUE_CNT_W'(1));
        end
    end

    always_comb begin
        queue_next = queue_reg;
        cnt_next   = cnt_reg;
        if (s_fire) begin
            queue_next = load_items;
            cnt_next   = load_cnt;
        end else if (m_fire) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                queue_next[i] = queue_reg[i + 1];
            end
            cnt_next = cnt_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        queue_reg <= queue_next;
        if (!aresetn) begin
            base_lba_reg     <= '0;
            part_sect_reg    <= '0;
            poll_limit_reg   <= POLL_LIMIT_RESET;
            phase_reg        <= PH_IDLE;
            write_mode_reg   <= 1'b0;
            bus_sel_reg      <= 1'b0;
            sectors_left_reg <= '0;
            word_index_reg   <= '0;
            spin_count_reg   <= '0;
            cnt_reg          <= '0;
        end else begin
            phase_reg        <= phase_next;
            write_mode_reg   <= write_mode_next;
            bus_sel_reg      <= bus_sel_next;
            sectors_left_reg <= sectors_left_next;
            word_index_reg   <= word_index_next;
            spin_count_reg   <= spin_count_next;
            cnt_reg          <= cnt_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BASE_LBA:   base_lba_reg   <= cfg_data[27:0];
                    CFG_PART_SECT:  part_sect_reg  <= cfg_data;
                    CFG_POLL_LIMIT: poll_limit_reg <= cfg_data[23:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    `APIO_ASSERT_NOW(a_queue_bound, 1'b1, cnt_reg <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue overfull")
    `APIO_ASSERT_NOW(a_final_last, m_valid && (cnt_reg == QUEUE_CNT_W'(1)), m_data.last, "final result without last")
    `APIO_ASSERT_NEXT(a_start_ignored, s_fire && (s_data.op == OP_START) && (phase_reg != PH_IDLE), cnt_reg == '0, "ignored start produced results")
    `APIO_ASSERT_NOW(a_sectors_live, (phase_reg == PH_BUSY) || (phase_reg == PH_DRQ) || (phase_reg == PH_DATA), sectors_left_reg != '0, "active transfer with no sectors left")

endmodule
